// ===== rtl/core/cswk_pkg.sv =====
// Shared types and constants of the clipped shape fill walker.
`default_nettype none

package cswk_pkg;

  localparam int unsigned DimW    = 13;
  localparam int unsigned ScanW   = 14;
  localparam int unsigned CoordW  = 16;
  localparam int unsigned AddrW   = 24;
  localparam int unsigned ColorW  = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 32;

  localparam logic [CfgIdxW-1:0] CfgFbWidth   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgFbHeight  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgShapeMode = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgAnchorX   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgAnchorY   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgSizeA     = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgSizeB     = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgFillColor = 3'd7;

  typedef struct packed {
    logic [DimW-1:0]   fb_width;
    logic [DimW-1:0]   fb_height;
    logic              shape_mode;
    logic [CoordW-1:0] anchor_x;
    logic [CoordW-1:0] anchor_y;
    logic [DimW-1:0]   size_a;
    logic [DimW-1:0]   size_b;
    logic [ColorW-1:0] fill_color;
  } cfg_t;

  typedef struct packed {
    logic             act;
    logic             last;
    logic [ScanW-1:0] col;
    logic [ScanW-1:0] row;
  } pos_t;

endpackage

`default_nettype wire

// ===== rtl/core/cswk_req_if.sv =====
// Request channel of the fill walker: one start or advance tick.
`default_nettype none

interface cswk_req_if;
  logic valid;
  logic ready;
  logic start_req;

  modport source (output valid, output start_req, input ready);
  modport sink (input valid, input start_req, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cswk_res_if.sv =====
// Result channel of the fill walker: one pixel result per request.
`default_nettype none

interface cswk_res_if;
  logic                              valid;
  logic                              ready;
  logic [cswk_pkg::AddrW-1:0]        pixel_address;
  logic                              write_enable;
  logic [cswk_pkg::ColorW-1:0]       pixel_value;
  logic                              done_res;

  modport source (output valid, output pixel_address, output write_enable,
                  output pixel_value, output done_res, input ready);
  modport sink (input valid, input pixel_address, input write_enable,
                input pixel_value, input done_res, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cswk_walk.sv =====
// Walk sequencer: bounding-box scan state and the registered scan position.
`default_nettype none

module cswk_walk (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire cswk_pkg::cfg_t  cfg_i,
  input  wire logic            adv_i,
  input  wire logic            req_valid_i,
  input  wire logic            start_req_i,
  output logic                 pos_valid_o,
  output cswk_pkg::pos_t       pos_o
);

  localparam int unsigned SW = cswk_pkg::ScanW;

  logic [SW-1:0] col_q, col_d;
  logic [SW-1:0] row_q, row_d;
  logic          walk_q, walk_d;
  logic          pos_valid_q;
  cswk_pkg::pos_t pos_q, pos_d;

  logic [SW-1:0] bw, bh, bw_m1, bh_m1;
  logic [SW-1:0] col, row;
  logic          act_in, in_box, last, accept;

  assign accept = adv_i && req_valid_i;

  always_comb begin
    if (cfg_i.shape_mode) begin
      bw = {cfg_i.size_a, 1'b1};
      bh = {cfg_i.size_a, 1'b1};
    end else begin
      bw = (cfg_i.size_b == '0) ? '0 : {1'b0, cfg_i.size_a};
      bh = (cfg_i.size_a == '0) ? '0 : {1'b0, cfg_i.size_b};
    end
  end

  assign bw_m1 = bw - SW'(1);
  assign bh_m1 = bh - SW'(1);

  always_comb begin
    act_in = start_req_i || walk_q;
    col    = start_req_i ? '0 : col_q;
    row    = start_req_i ? '0 : row_q;
    in_box = act_in && (bw != '0) && (bh != '0) && (col < bw) && (row < bh);
    last   = (col == bw_m1) && (row == bh_m1);

    col_d  = col;
    row_d  = row;
    walk_d = in_box && !last;
    if (in_box && !last) begin
      if (col == bw_m1) begin
        col_d = '0;
        row_d = row + SW'(1);
      end else begin
        col_d = col + SW'(1);
      end
    end

    pos_d.act  = in_box;
    pos_d.last = in_box && last;
    pos_d.col  = col;
    pos_d.row  = row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      walk_q      <= 1'b0;
      pos_valid_q <= 1'b0;
    end else begin
      if (adv_i) begin
        pos_valid_q <= req_valid_i;
      end
      if (accept) begin
        col_q  <= col_d;
        row_q  <= row_d;
        walk_q <= walk_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos_q <= pos_d;
    end
  end

  assign pos_valid_o = pos_valid_q;
  assign pos_o       = pos_q;

`ifndef ASSERT_OFF
  a_pos_in_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_valid_q && pos_q.act |-> (pos_q.col < bw) && (pos_q.row < bh))
    else $error("scan position outside bounding box");

  a_walk_follows_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_valid_q |-> walk_q == (pos_q.act && !pos_q.last))
    else $error("walk state disagrees with last issued position");

  a_last_is_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_valid_q && pos_q.last |-> pos_q.act)
    else $error("last flag on an inactive position");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/clipped_shape_fill_walker.sv =====
// Clipped rectangle and filled circle fill walker, top level.
//
// Usage:
//   Program the frame size, shape mode, anchor, extents and color through the
//   write port (cfg_we_i, cfg_idx_i, cfg_data_i) while no request is pending.
//   Each request on req_i (start_req high restarts the walk, low advances one
//   position) yields exactly one result on res_o: the linear pixel address,
//   a write enable for positions inside frame and shape, the color and a
//   done flag that marks the last position or an idle walk.
//   On its way to res_o a request passes three registers: scan position
//   register, product register (row times stride and the circle squares),
//   result register. Throughput is one request per cycle unless the receiver
//   stalls; the walk counters update in the request cycle: no bubbles.
//   When the receiver stalls, the three stages fill and req_i.ready drops
//   only once all of them hold a result; results are never dropped.
//   Reset clears the walk (idle), the pipeline valids and loads the default
//   registers: 640 by 480 frame, rectangle mode, zero anchor, extents, color.
`default_nettype none

module clipped_shape_fill_walker #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [cswk_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [cswk_pkg::CfgW-1:0]       cfg_data_i,
  cswk_req_if.sink                             req_i,
  cswk_res_if.source                           res_o
);

  localparam int unsigned DW = cswk_pkg::DimW;
  localparam int unsigned SW = cswk_pkg::ScanW;
  localparam int unsigned CW = cswk_pkg::CoordW;
  localparam int unsigned XW = 18;
  localparam logic [DW:0] MaxDim = (DW+1)'(MAX_DIM);

  cswk_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fb_width   <= DW'(640);
      cfg_q.fb_height  <= DW'(480);
      cfg_q.shape_mode <= 1'b0;
      cfg_q.anchor_x   <= '0;
      cfg_q.anchor_y   <= '0;
      cfg_q.size_a     <= '0;
      cfg_q.size_b     <= '0;
      cfg_q.fill_color <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cswk_pkg::CfgFbWidth:   cfg_q.fb_width   <= cfg_data_i[DW-1:0];
        cswk_pkg::CfgFbHeight:  cfg_q.fb_height  <= cfg_data_i[DW-1:0];
        cswk_pkg::CfgShapeMode: cfg_q.shape_mode <= cfg_data_i[0];
        cswk_pkg::CfgAnchorX:   cfg_q.anchor_x   <= cfg_data_i[CW-1:0];
        cswk_pkg::CfgAnchorY:   cfg_q.anchor_y   <= cfg_data_i[CW-1:0];
        cswk_pkg::CfgSizeA:     cfg_q.size_a     <= cfg_data_i[DW-1:0];
        cswk_pkg::CfgSizeB:     cfg_q.size_b     <= cfg_data_i[DW-1:0];
        cswk_pkg::CfgFillColor: cfg_q.fill_color <= cfg_data_i[cswk_pkg::ColorW-1:0];
        default: ;
      endcase
    end
  end

  // Stage enables: each stage takes new data when empty or when it drains.
  logic en1, en2, en3;
  logic v1, v2_q, v3_q;

  assign en3 = !v3_q || res_o.ready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1 || en2;
  assign req_i.ready = en1;

  cswk_pkg::pos_t pos;

  cswk_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .adv_i       (en1),
    .req_valid_i (req_i.valid),
    .start_req_i (req_i.start_req),
    .pos_valid_o (v1),
    .pos_o       (pos)
  );

  // Position and clip test, products.
  logic [DW-1:0]  fw, fh, off;
  logic [XW-1:0]  x, y;
  logic           inframe;
  logic [SW:0]    dx, dy;
  logic [SW-1:0]  dxa, dya;

  always_comb begin
    fw  = ({1'b0, cfg_q.fb_width} > MaxDim) ? MaxDim[DW-1:0] : cfg_q.fb_width;
    fh  = ({1'b0, cfg_q.fb_height} > MaxDim) ? MaxDim[DW-1:0] : cfg_q.fb_height;
    off = cfg_q.shape_mode ? cfg_q.size_a : '0;
    x = {{(XW-CW){cfg_q.anchor_x[CW-1]}}, cfg_q.anchor_x} - XW'(off) + XW'(pos.col);
    y = {{(XW-CW){cfg_q.anchor_y[CW-1]}}, cfg_q.anchor_y} - XW'(off) + XW'(pos.row);
    inframe = pos.act && !x[XW-1] && !y[XW-1]
              && (x[XW-2:0] < (XW-1)'(fw)) && (y[XW-2:0] < (XW-1)'(fh));
    dx  = {1'b0, pos.col} - (SW+1)'(cfg_q.size_a);
    dy  = {1'b0, pos.row} - (SW+1)'(cfg_q.size_a);
    dxa = dx[SW] ? SW'(-dx) : dx[SW-1:0];
    dya = dy[SW] ? SW'(-dy) : dy[SW-1:0];
  end

  logic              act2_q, last2_q, inframe2_q;
  logic [2*DW-1:0]   prod_q, r2_q;
  logic [DW-1:0]     xlo_q;
  logic [2*SW-1:0]   dx2_q, dy2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1) begin
      act2_q     <= pos.act;
      last2_q    <= pos.last;
      inframe2_q <= inframe;
      prod_q     <= y[DW-1:0] * fw;
      xlo_q      <= x[DW-1:0];
      dx2_q      <= dxa * dxa;
      dy2_q      <= dya * dya;
      r2_q       <= cfg_q.size_a * cfg_q.size_a;
    end
  end

  // Address sum, circle test, result register.
  logic [2*SW:0]                  dist2;
  logic [2*DW:0]                  addr_sum;
  logic                           we3;
  logic [cswk_pkg::AddrW-1:0]     addr_q;
  logic                           we_q, done_q;
  logic [cswk_pkg::ColorW-1:0]    value_q;

  always_comb begin
    dist2    = (2*SW+1)'(dx2_q) + (2*SW+1)'(dy2_q);
    addr_sum = (2*DW+1)'(prod_q) + (2*DW+1)'(xlo_q);
    we3      = inframe2_q && (!cfg_q.shape_mode || (dist2 <= (2*SW+1)'(r2_q)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      addr_q  <= inframe2_q ? addr_sum[cswk_pkg::AddrW-1:0] : '0;
      we_q    <= we3;
      value_q <= we3 ? cfg_q.fill_color : '0;
      done_q  <= !act2_q || last2_q;
    end
  end

  assign res_o.valid         = v3_q;
  assign res_o.pixel_address = addr_q;
  assign res_o.write_enable  = we_q;
  assign res_o.pixel_value   = value_q;
  assign res_o.done_res      = done_q;

`ifndef ASSERT_OFF
  a_we_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.write_enable |-> res_o.pixel_value == cfg_q.fill_color)
    else $error("write without fill color");

  a_no_we_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.write_enable |-> res_o.pixel_value == '0)
    else $error("nonzero value on a skipped position");

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> v1 && v2_q && v3_q && !res_o.ready)
    else $error("request refused with room in the pipeline");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_clipped_shape_fill_walker.sv =====
// Testbench for the clipped shape fill walker: predicted pixel stream checked per request.
module tb_clipped_shape_fill_walker;

  localparam int unsigned MaxDim        = 4096;
  localparam int unsigned ScanBits      = 17;
  localparam int unsigned PipeDepth     = 3;
  localparam int unsigned HoldOffCycles = 60;
  localparam int unsigned RandomTicks   = 550;
  localparam int unsigned CalmTicks     = 480;

  typedef struct packed {
    logic [cswk_pkg::AddrW-1:0]  addr;
    logic                        we;
    logic [cswk_pkg::ColorW-1:0] value;
    logic                        done;
  } pixel_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we;
  logic [cswk_pkg::CfgIdxW-1:0] cfg_idx;
  logic [cswk_pkg::CfgW-1:0]    cfg_data;

  cswk_req_if req_if ();
  cswk_res_if res_if ();

  clipped_shape_fill_walker #(
    .MAX_DIM(MaxDim)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .req_i     (req_if),
    .res_o     (res_if)
  );

  logic [cswk_pkg::DimW-1:0]   fb_w;
  logic [cswk_pkg::DimW-1:0]   fb_h;
  logic                        circle_mode;
  logic [cswk_pkg::CoordW-1:0] anc_x;
  logic [cswk_pkg::CoordW-1:0] anc_y;
  logic [cswk_pkg::DimW-1:0]   ext_a;
  logic [cswk_pkg::DimW-1:0]   ext_b;
  logic [cswk_pkg::ColorW-1:0] color;
  logic [ScanBits-1:0]         col_pos;
  logic [ScanBits-1:0]         row_pos;
  logic                        walking;

  logic   tick_q[$];
  pixel_t pixel_q[$];

  bit          calm;
  bit          hold_ask;
  bit          hold_taken;
  int unsigned tick_gap;
  int unsigned stall_left;
  int unsigned hold_left;
  int unsigned mismatches;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic void box_dims(output int unsigned bw, output int unsigned bh);
    if (circle_mode) begin
      bw = 2 * int'(ext_a) + 1;
      bh = bw;
    end else begin
      bw = (ext_b == 0) ? 0 : ext_a;
      bh = (ext_a == 0) ? 0 : ext_b;
    end
  endfunction

  task automatic next_pixel(input logic start, output pixel_t px);
    int unsigned bw;
    int unsigned bh;
    longint      ox;
    longint      oy;
    longint      x;
    longint      y;
    longint      fw;
    longint      fh;
    longint      dx;
    longint      dy;
    longint      r;
    logic [63:0] lin;
    logic        covered;
    logic        is_last;
    px = '0;
    box_dims(bw, bh);
    if (start) begin
      col_pos = '0;
      row_pos = '0;
      walking = 1'b1;
    end
    if (walking && (bw == 0 || bh == 0 || col_pos >= bw || row_pos >= bh)) begin
      walking = 1'b0;
    end
    if (!walking) begin
      px.done = 1'b1;
    end else begin
      ox = longint'($signed(anc_x));
      oy = longint'($signed(anc_y));
      if (circle_mode) begin
        ox = ox - longint'(ext_a);
        oy = oy - longint'(ext_a);
      end
      x = ox + longint'(col_pos);
      y = oy + longint'(row_pos);
      fw = (fb_w > MaxDim) ? MaxDim : fb_w;
      fh = (fb_h > MaxDim) ? MaxDim : fb_h;
      covered = 1'b0;
      if (x >= 0 && x < fw && y >= 0 && y < fh) begin
        lin = y * fw + x;
        px.addr = lin[cswk_pkg::AddrW-1:0];
        covered = 1'b1;
        if (circle_mode) begin
          dx = longint'(col_pos) - longint'(ext_a);
          dy = longint'(row_pos) - longint'(ext_a);
          r = longint'(ext_a);
          covered = (dx * dx + dy * dy) <= r * r;
        end
      end
      is_last = (col_pos == bw - 1) && (row_pos == bh - 1);
      px.we = covered;
      px.value = covered ? color : '0;
      px.done = is_last;
      if (is_last) begin
        walking = 1'b0;
      end else if (col_pos == bw - 1) begin
        col_pos = '0;
        row_pos = row_pos + 1'b1;
      end else begin
        col_pos = col_pos + 1'b1;
      end
    end
  endtask

  task automatic write_reg(input logic [cswk_pkg::CfgIdxW-1:0] idx,
                           input logic [cswk_pkg::CfgW-1:0] data);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    case (idx)
      cswk_pkg::CfgFbWidth:   fb_w = data[cswk_pkg::DimW-1:0];
      cswk_pkg::CfgFbHeight:  fb_h = data[cswk_pkg::DimW-1:0];
      cswk_pkg::CfgShapeMode: circle_mode = data[0];
      cswk_pkg::CfgAnchorX:   anc_x = data[cswk_pkg::CoordW-1:0];
      cswk_pkg::CfgAnchorY:   anc_y = data[cswk_pkg::CoordW-1:0];
      cswk_pkg::CfgSizeA:     ext_a = data[cswk_pkg::DimW-1:0];
      cswk_pkg::CfgSizeB:     ext_b = data[cswk_pkg::DimW-1:0];
      default:                color = data[cswk_pkg::ColorW-1:0];
    endcase
  endtask

  task automatic close_writes();
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_walk(input bit with_start, input int unsigned n_adv, input bit noisy);
    @(negedge clk_i);
    if (with_start) begin
      tick_q.push_back(1'b1);
    end
    repeat (n_adv) begin
      tick_q.push_back(noisy && $urandom_range(0, 11) == 0);
    end
  endtask

  task automatic settle();
    @(negedge clk_i);
    while (tick_q.size() != 0 || req_if.valid || pixel_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (PipeDepth + 1) @(posedge clk_i);
  endtask

  function automatic logic [cswk_pkg::CfgW-1:0] pick_value(
      input logic [cswk_pkg::CfgIdxW-1:0] idx, input bit big);
    logic [cswk_pkg::CfgW-1:0] v;
    int                        s;
    v = '0;
    s = 0;
    case (idx)
      cswk_pkg::CfgFbWidth, cswk_pkg::CfgFbHeight: begin
        if (big) begin
          v = MaxDim;
        end else begin
          case ($urandom_range(0, 9))
            0:       v = 0;
            1:       v = MaxDim;
            2:       v = 8191;
            3:       v = $urandom_range(MaxDim + 1, 8191);
            4, 5:    v = $urandom_range(1, MaxDim);
            default: v = $urandom_range(1, 40);
          endcase
        end
      end
      cswk_pkg::CfgShapeMode: v = $urandom_range(0, 1);
      cswk_pkg::CfgAnchorX, cswk_pkg::CfgAnchorY: begin
        if (big) begin
          v = $urandom_range(0, MaxDim - 1);
        end else begin
          case ($urandom_range(0, 9))
            0:       v = 16'h7FFF;
            1:       v = 16'h8000;
            2:       v = $urandom_range(0, 16'hFFFF);
            3:       v = $urandom_range(0, MaxDim - 1);
            default: begin
              s = int'($urandom_range(0, 51)) - 6;
              v = {16'h0, s[15:0]};
            end
          endcase
        end
      end
      cswk_pkg::CfgSizeA, cswk_pkg::CfgSizeB: begin
        case ($urandom_range(0, 7))
          0:       v = 0;
          1:       v = 8191;
          2:       v = $urandom_range(0, 8191);
          default: v = $urandom_range(1, 5);
        endcase
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : drive_ticks
    pixel_t px;
    logic   offer;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.start_req <= 1'b0;
      tick_gap = 0;
      col_pos = '0;
      row_pos = '0;
      walking = 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        next_pixel(req_if.start_req, px);
        pixel_q.push_back(px);
      end
      if (!req_if.valid || req_if.ready) begin
        offer = 1'b0;
        if (tick_gap > 0) begin
          tick_gap--;
        end else if (tick_q.size() > 0) begin
          if (!calm && $urandom_range(0, 5) == 0) begin
            tick_gap = $urandom_range(0, 8);
          end else begin
            offer = 1'b1;
            req_if.start_req <= tick_q.pop_front();
          end
        end
        req_if.valid <= offer;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : check_pixels
    pixel_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
      hold_taken = 1'b0;
      mismatches = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (pixel_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected pixel: addr=%h we=%b val=%h done=%b",
                     res_if.pixel_address, res_if.write_enable, res_if.pixel_value,
                     res_if.done_res);
          end
        end else begin
          want = pixel_q.pop_front();
          if (res_if.pixel_address !== want.addr || res_if.write_enable !== want.we ||
              res_if.pixel_value !== want.value || res_if.done_res !== want.done) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("pixel mismatch: want %h %b %h %b, got %h %b %h %b",
                       want.addr, want.we, want.value, want.done, res_if.pixel_address,
                       res_if.write_enable, res_if.pixel_value, res_if.done_res);
            end
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (hold_ask && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HoldOffCycles - 1;
        res_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 8);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int unsigned     placed;
    int unsigned     n_adv;
    int unsigned     bw;
    int unsigned     bh;
    longint unsigned cells;
    bit              first;
    bit              big;
    bit              noisy;
    bit              with_start;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = cswk_pkg::CfgFbWidth;
    cfg_data = '0;
    calm = 1'b0;
    hold_ask = 1'b0;
    fb_w = 640;
    fb_h = 480;
    circle_mode = 1'b0;
    anc_x = '0;
    anc_y = '0;
    ext_a = '0;
    ext_b = '0;
    color = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // idle tick, then a start on the empty rectangle left by reset
    queue_walk(1'b0, 1, 1'b0);
    queue_walk(1'b1, 0, 1'b0);
    settle();

    write_reg(cswk_pkg::CfgFbWidth, 8);
    write_reg(cswk_pkg::CfgFbHeight, 6);
    write_reg(cswk_pkg::CfgShapeMode, 0);
    write_reg(cswk_pkg::CfgAnchorX, 2);
    write_reg(cswk_pkg::CfgAnchorY, 3);
    write_reg(cswk_pkg::CfgSizeA, 3);
    write_reg(cswk_pkg::CfgSizeB, 2);
    write_reg(cswk_pkg::CfgFillColor, 32'hFFFF_FFFF);
    close_writes();
    queue_walk(1'b1, 5, 1'b0);
    settle();

    // rectangle hanging off the top left corner of a one pixel frame
    write_reg(cswk_pkg::CfgFbWidth, 1);
    write_reg(cswk_pkg::CfgFbHeight, 1);
    write_reg(cswk_pkg::CfgAnchorX, 16'hFFFF);
    write_reg(cswk_pkg::CfgAnchorY, 16'hFFFF);
    write_reg(cswk_pkg::CfgSizeA, 2);
    write_reg(cswk_pkg::CfgFillColor, 32'h0);
    close_writes();
    queue_walk(1'b1, 3, 1'b0);
    settle();

    write_reg(cswk_pkg::CfgFbWidth, 8191);
    write_reg(cswk_pkg::CfgFbHeight, 8191);
    write_reg(cswk_pkg::CfgShapeMode, 1);
    write_reg(cswk_pkg::CfgAnchorX, 1);
    write_reg(cswk_pkg::CfgAnchorY, 1);
    write_reg(cswk_pkg::CfgSizeA, 1);
    write_reg(cswk_pkg::CfgFillColor, 32'hA5A5_5A5A);
    close_writes();
    queue_walk(1'b1, 8, 1'b0);
    settle();

    write_reg(cswk_pkg::CfgSizeA, 0);
    close_writes();
    queue_walk(1'b1, 1, 1'b0);
    settle();

    write_reg(cswk_pkg::CfgShapeMode, 0);
    write_reg(cswk_pkg::CfgFbWidth, 0);
    write_reg(cswk_pkg::CfgFbHeight, MaxDim);
    write_reg(cswk_pkg::CfgAnchorX, 16'h7FFF);
    write_reg(cswk_pkg::CfgAnchorY, 16'h8000);
    write_reg(cswk_pkg::CfgSizeA, 8191);
    write_reg(cswk_pkg::CfgSizeB, 8191);
    close_writes();
    queue_walk(1'b1, 1, 1'b0);
    settle();

    // shrink the box under a running walk
    write_reg(cswk_pkg::CfgFbWidth, 64);
    write_reg(cswk_pkg::CfgFbHeight, 64);
    write_reg(cswk_pkg::CfgAnchorX, 0);
    write_reg(cswk_pkg::CfgAnchorY, 0);
    write_reg(cswk_pkg::CfgSizeA, 4);
    write_reg(cswk_pkg::CfgSizeB, 4);
    close_writes();
    queue_walk(1'b1, 2, 1'b0);
    settle();
    write_reg(cswk_pkg::CfgSizeA, 1);
    close_writes();
    queue_walk(1'b0, 1, 1'b0);
    settle();

    first = 1'b1;
    placed = 0;
    while (placed < RandomTicks) begin
      if (placed >= CalmTicks) begin
        calm = 1'b1;
      end
      big = ($urandom_range(0, 4) == 0);
      for (int i = 0; i <= cswk_pkg::CfgFillColor; i++) begin
        if (first || big || $urandom_range(0, 1) == 1) begin
          write_reg(cswk_pkg::CfgIdxW'(i), pick_value(cswk_pkg::CfgIdxW'(i), big));
        end
      end
      close_writes();
      box_dims(bw, bh);
      cells = longint'(bw) * longint'(bh);
      noisy = ($urandom_range(0, 3) == 0);
      with_start = first || ($urandom_range(0, 5) != 0);
      if (first) begin
        n_adv = 45;
      end else if (cells == 0) begin
        n_adv = $urandom_range(0, 3);
      end else if (cells <= 60) begin
        n_adv = int'(cells) - 1 + $urandom_range(0, 2);
      end else begin
        n_adv = $urandom_range(4, 30);
      end
      queue_walk(with_start, n_adv, noisy);
      if (first) begin
        hold_ask = 1'b1;
      end
      placed += n_adv + with_start;
      first = 1'b0;
      settle();
    end

    repeat (PipeDepth * 3) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #(4_000_000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/cswk_pkg.sv
rtl/core/cswk_req_if.sv
rtl/core/cswk_res_if.sv
rtl/core/cswk_walk.sv
rtl/core/clipped_shape_fill_walker.sv
bench/tb_clipped_shape_fill_walker.sv
